// ===== rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the power source selector.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned SLOTS  = 3;
  localparam int unsigned VOLT_W = 12;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN = 2'd0,
    TYPE_LI      = 2'd1,
    TYPE_ADAPTER = 2'd2,
    TYPE_DRY     = 2'd3
  } slot_type_e;

  localparam logic [1:0] SLOT_A   = 2'd0;
  localparam logic [1:0] SLOT_B   = 2'd1;
  localparam logic [1:0] SLOT_C   = 2'd2;
  localparam logic [1:0] SRC_NONE = 2'd2;

  localparam logic       REQ_FULL  = 1'b0;
  localparam logic       REQ_QUICK = 1'b1;

  localparam logic [5:0] PINS_A    = 6'h1F;
  localparam logic [5:0] PINS_B    = 6'h10;
  localparam logic [5:0] PINS_NONE = 6'h2C;

  localparam logic [1:0] REG_MIN_VOLTAGE  = 2'd0;
  localparam logic [1:0] REG_MAX_VOLTAGE  = 2'd1;
  localparam logic [1:0] REG_DETECT_LEVEL = 2'd2;

  localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST  = 12'd0;
  localparam logic [VOLT_W-1:0] MAX_VOLTAGE_RST  = 12'd4095;
  localparam logic [VOLT_W-1:0] DETECT_LEVEL_RST = 12'd100;

  typedef struct packed {
    logic [VOLT_W-1:0] min_voltage;
    logic [VOLT_W-1:0] max_voltage;
    logic [VOLT_W-1:0] detect_level;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        slot;
    logic [VOLT_W-1:0] sample;
    logic              li_answered;
  } item_t;

  typedef struct packed {
    slot_type_e        src_type;
    logic              ok;
    logic [VOLT_W-1:0] level;
  } slot_rec_t;

  typedef slot_rec_t [SLOTS-1:0] slot_recs_t;

  typedef struct packed {
    slot_type_e slot_type;
    logic       slot_available;
    logic       indicator_on;
  } check_t;

  typedef struct packed {
    logic [1:0] selected_source;
    logic [5:0] switch_pins;
  } select_t;

endpackage

// ===== rtl/pss_slot_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_slot_bank
// Slot records and their per-word classification and availability update.
// ----------------------------------------------------------------------------
module pss_slot_bank (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_en_i,
  input  pss_pkg::item_t     item_i,
  input  pss_pkg::cfg_t      cfg_i,
  output pss_pkg::slot_recs_t recs_next_o,
  output pss_pkg::slot_recs_t recs_o,
  output pss_pkg::check_t    check_o
);

  pss_pkg::slot_recs_t recs_q, recs_d;
  pss_pkg::slot_rec_t  cur;
  pss_pkg::check_t     check;
  logic                in_win;
  logic                out_win;

  assign in_win  = (item_i.sample > cfg_i.min_voltage) && (item_i.sample < cfg_i.max_voltage);
  assign out_win = (item_i.sample < cfg_i.min_voltage) || (item_i.sample > cfg_i.max_voltage);

  always_comb begin
    recs_d = recs_q;
    cur    = recs_q[0];
    check  = '{slot_type: pss_pkg::TYPE_UNKNOWN, slot_available: 1'b0, indicator_on: 1'b0};
    if (item_i.slot != 2'd3) begin
      cur = recs_q[item_i.slot];
      if (item_i.req_type == pss_pkg::REQ_QUICK) begin
        if (out_win) begin
          cur.ok = 1'b0;
        end
      end else begin
        if (in_win) begin
          if (!cur.ok && cur.src_type == pss_pkg::TYPE_UNKNOWN) begin
            cur.ok = 1'b1;
          end
        end else begin
          cur.ok = 1'b0;
        end
        if (item_i.slot != pss_pkg::SLOT_C) begin
          check.indicator_on = !item_i.li_answered;
          if (item_i.li_answered) begin
            cur.src_type = pss_pkg::TYPE_LI;
          end else if (item_i.sample > cfg_i.detect_level) begin
            cur.src_type = pss_pkg::TYPE_ADAPTER;
          end else begin
            cur.src_type = pss_pkg::TYPE_UNKNOWN;
          end
        end else begin
          cur.src_type = (item_i.sample < cfg_i.detect_level) ? pss_pkg::TYPE_UNKNOWN
                                                               : pss_pkg::TYPE_DRY;
        end
        cur.level = item_i.sample;
      end
      recs_d[item_i.slot]  = cur;
      check.slot_type      = cur.src_type;
      check.slot_available = cur.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pss_pkg::SLOTS; i++) begin
        recs_q[i] <= '{src_type: pss_pkg::TYPE_UNKNOWN, ok: 1'b0, level: '0};
      end
    end else if (upd_en_i) begin
      recs_q <= recs_d;
    end
  end

  assign recs_next_o = recs_d;
  assign recs_o      = recs_q;
  assign check_o     = check;

endmodule

// ===== rtl/pss_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_select
// Source selection from slots A and B and switch pin decode.
// ----------------------------------------------------------------------------
module pss_select (
  input  pss_pkg::slot_rec_t rec_a_i,
  input  pss_pkg::slot_rec_t rec_b_i,
  output pss_pkg::select_t   sel_o
);

  logic       higher_a;
  logic [1:0] src;

  assign higher_a = rec_a_i.level > rec_b_i.level;

  always_comb begin
    if (rec_a_i.ok && rec_b_i.ok) begin
      if (rec_a_i.src_type == pss_pkg::TYPE_ADAPTER) begin
        if (rec_b_i.src_type == pss_pkg::TYPE_LI) begin
          src = pss_pkg::SLOT_A;
        end else begin
          src = higher_a ? pss_pkg::SLOT_B : pss_pkg::SLOT_A;
        end
      end else if (rec_b_i.src_type == pss_pkg::TYPE_ADAPTER) begin
        src = pss_pkg::SLOT_B;
      end else begin
        src = higher_a ? pss_pkg::SLOT_B : pss_pkg::SLOT_A;
      end
    end else if (rec_a_i.ok) begin
      src = pss_pkg::SLOT_A;
    end else if (rec_b_i.ok) begin
      src = pss_pkg::SLOT_B;
    end else begin
      src = pss_pkg::SRC_NONE;
    end
  end

  always_comb begin
    sel_o.selected_source = src;
    case (src)
      pss_pkg::SLOT_A: sel_o.switch_pins = pss_pkg::PINS_A;
      pss_pkg::SLOT_B: sel_o.switch_pins = pss_pkg::PINS_B;
      default:         sel_o.switch_pins = pss_pkg::PINS_NONE;
    endcase
  end

endmodule

// ===== rtl/power_source_selector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_source_selector_top
// Three-slot supply classifier and source selector with stream ports.
// ----------------------------------------------------------------------------
// Takes one check word per clock cycle while the output is not stalled and
// presents one result word for each: the word is captured in an input register,
// the addressed slot record is classified and updated and the source
// re-selected in a single pass, and the result lands in an output register.
// Window and detect levels are to be written through the register port only
// while no word is in flight; the block itself does not enforce this.
module power_source_selector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[11:0], li_answered[12], zero
  input  logic [2:0]  s_axis_tuser,   // req_type[0], slot[2:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // selected_source[1:0], switch_pins[7:2],
                                      // slot_type[9:8], slot_available[10],
                                      // indicator_on[11], zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pss_pkg::cfg_t       cfg_q;
  pss_pkg::item_t      item_q;
  logic                in_valid_q;
  logic                out_valid_q;
  logic [15:0]         out_data_q;
  logic                advance;
  logic                proc;
  logic                wr_en;
  pss_pkg::slot_recs_t recs_next;
  pss_pkg::slot_recs_t recs;
  pss_pkg::check_t     check;
  pss_pkg::select_t    sel;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_voltage  <= pss_pkg::MIN_VOLTAGE_RST;
      cfg_q.max_voltage  <= pss_pkg::MAX_VOLTAGE_RST;
      cfg_q.detect_level <= pss_pkg::DETECT_LEVEL_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        pss_pkg::REG_MIN_VOLTAGE:  cfg_q.min_voltage  <= pwdata[11:0];
        pss_pkg::REG_MAX_VOLTAGE:  cfg_q.max_voltage  <= pwdata[11:0];
        pss_pkg::REG_DETECT_LEVEL: cfg_q.detect_level <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pss_pkg::REG_MIN_VOLTAGE:  prdata = {20'd0, cfg_q.min_voltage};
      pss_pkg::REG_MAX_VOLTAGE:  prdata = {20'd0, cfg_q.max_voltage};
      pss_pkg::REG_DETECT_LEVEL: prdata = {20'd0, cfg_q.detect_level};
      default:                   prdata = 32'd0;
    endcase
  end

  // input register
  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req_type    <= s_axis_tuser[0];
      item_q.slot        <= s_axis_tuser[2:1];
      item_q.sample      <= s_axis_tdata[11:0];
      item_q.li_answered <= s_axis_tdata[12];
    end
  end

  pss_slot_bank u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_en_i    (proc),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .recs_next_o (recs_next),
    .recs_o      (recs),
    .check_o     (check)
  );

  pss_select u_select (
    .rec_a_i (recs_next[0]),
    .rec_b_i (recs_next[1]),
    .sel_o   (sel)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_data_q <= {4'd0, check.indicator_on, check.slot_available, check.slot_type,
                     sel.switch_pins, sel.selected_source};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_pins_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[1:0] == pss_pkg::SLOT_A && m_axis_tdata[7:2] == pss_pkg::PINS_A) ||
       (m_axis_tdata[1:0] == pss_pkg::SLOT_B && m_axis_tdata[7:2] == pss_pkg::PINS_B) ||
       (m_axis_tdata[1:0] == pss_pkg::SRC_NONE && m_axis_tdata[7:2] == pss_pkg::PINS_NONE)))
    else $error("switch pins disagree with selected source");

  a_ab_never_dry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recs[0].src_type != pss_pkg::TYPE_DRY && recs[1].src_type != pss_pkg::TYPE_DRY)
    else $error("slot a or b classed as dry battery");

  a_c_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recs[2].src_type == pss_pkg::TYPE_UNKNOWN || recs[2].src_type == pss_pkg::TYPE_DRY)
    else $error("slot c classed as lithium or adapter");

  a_ok_from_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(recs[0].ok) |-> $past(recs[0].src_type == pss_pkg::TYPE_UNKNOWN && proc))
    else $error("slot a became available without unknown type");

endmodule

// ===== tb/sv/tb_power_source_selector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_source_selector_top
// Self-checking stream testbench for the power source selector.
// ----------------------------------------------------------------------------
// Keeps its own copy of the three slot records and window settings, predicts
// each result word when its check word is accepted, and compares every result
// field by field in order. Directed words cover classification, window edges,
// the selection rules, quick checks, slot three and inverted windows; random
// traffic follows under changing window settings and three idle/stall mixes.
module tb_power_source_selector_top;

  localparam int unsigned LIMIT_CYCLES   = 200_000;
  localparam int unsigned WORDS_PER_SET  = 70;
  localparam int unsigned SETS_PER_PHASE = 5;

  typedef struct packed {
    logic [1:0]          sel;
    logic [5:0]          pins;
    pss_pkg::slot_type_e typ;
    logic                avail;
    logic                ind;
  } outcome_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [pss_pkg::VOLT_W-1:0] cfg_min = pss_pkg::MIN_VOLTAGE_RST;
  logic [pss_pkg::VOLT_W-1:0] cfg_max = pss_pkg::MAX_VOLTAGE_RST;
  logic [pss_pkg::VOLT_W-1:0] cfg_det = pss_pkg::DETECT_LEVEL_RST;
  pss_pkg::slot_type_e        rec_type  [pss_pkg::SLOTS] =
                                '{default: pss_pkg::TYPE_UNKNOWN};
  logic                       rec_ok    [pss_pkg::SLOTS] = '{default: 1'b0};
  logic [pss_pkg::VOLT_W-1:0] rec_level [pss_pkg::SLOTS] = '{default: '0};

  outcome_t pending_results [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_writes     = 0;
  int n_errors     = 0;
  int n_cycles     = 0;
  int n_directed   = 0;

  power_source_selector_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [1:0] pick_supply();
    logic a_higher;
    a_higher = rec_level[pss_pkg::SLOT_A] > rec_level[pss_pkg::SLOT_B];
    if (rec_ok[pss_pkg::SLOT_A] && rec_ok[pss_pkg::SLOT_B]) begin
      if (rec_type[pss_pkg::SLOT_A] == pss_pkg::TYPE_ADAPTER &&
          rec_type[pss_pkg::SLOT_B] == pss_pkg::TYPE_LI) return pss_pkg::SLOT_A;
      if (rec_type[pss_pkg::SLOT_A] != pss_pkg::TYPE_ADAPTER &&
          rec_type[pss_pkg::SLOT_B] == pss_pkg::TYPE_ADAPTER) return pss_pkg::SLOT_B;
      return a_higher ? pss_pkg::SLOT_B : pss_pkg::SLOT_A;
    end
    if (rec_ok[pss_pkg::SLOT_A]) return pss_pkg::SLOT_A;
    if (rec_ok[pss_pkg::SLOT_B]) return pss_pkg::SLOT_B;
    return pss_pkg::SRC_NONE;
  endfunction

  function automatic outcome_t predict_check(input logic req, input logic [1:0] slot,
                                             input logic [pss_pkg::VOLT_W-1:0] smp,
                                             input logic li);
    outcome_t o;
    o       = '0;
    o.typ   = pss_pkg::TYPE_UNKNOWN;
    if (slot < pss_pkg::SLOTS) begin
      if (req == pss_pkg::REQ_QUICK) begin
        if (smp < cfg_min || smp > cfg_max) rec_ok[slot] = 1'b0;
      end else begin
        if (!(smp > cfg_min && smp < cfg_max)) begin
          rec_ok[slot] = 1'b0;
        end else if (rec_type[slot] == pss_pkg::TYPE_UNKNOWN) begin
          rec_ok[slot] = 1'b1;
        end
        if (slot == pss_pkg::SLOT_C) begin
          if (smp < cfg_det) rec_type[slot] = pss_pkg::TYPE_UNKNOWN;
          else rec_type[slot] = pss_pkg::TYPE_DRY;
        end else begin
          o.ind = !li;
          if (li) rec_type[slot] = pss_pkg::TYPE_LI;
          else if (smp > cfg_det) rec_type[slot] = pss_pkg::TYPE_ADAPTER;
          else rec_type[slot] = pss_pkg::TYPE_UNKNOWN;
        end
        rec_level[slot] = smp;
      end
      o.typ   = rec_type[slot];
      o.avail = rec_ok[slot];
    end
    o.sel = pick_supply();
    case (o.sel)
      pss_pkg::SLOT_A: o.pins = pss_pkg::PINS_A;
      pss_pkg::SLOT_B: o.pins = pss_pkg::PINS_B;
      default:         o.pins = pss_pkg::PINS_NONE;
    endcase
    return o;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // input words are predicted at acceptance, result words checked in order
  always @(posedge clk_i) begin : scoreboard
    outcome_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_check(s_axis_tuser[0], s_axis_tuser[2:1],
                                                s_axis_tdata[11:0], s_axis_tdata[12]));
        n_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t result word with no check pending: expected none, got %h",
                   $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("selected_source", want.sel, m_axis_tdata[1:0]);
          check_field("switch_pins", want.pins, m_axis_tdata[7:2]);
          check_field("slot_type", int'(want.typ), m_axis_tdata[9:8]);
          check_field("slot_available", want.avail, m_axis_tdata[10]);
          check_field("indicator_on", want.ind, m_axis_tdata[11]);
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("[power_source_selector_top] ERROR");
      $finish;
    end
  end

  task automatic send_check(input logic req, input logic [1:0] slot,
                            input logic [pss_pkg::VOLT_W-1:0] smp, input logic li);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, li, smp};
    s_axis_tuser  <= {slot, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [1:0] idx, input logic [pss_pkg::VOLT_W-1:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    check_field($sformatf("register %0d", idx), {20'd0, want}, got);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [pss_pkg::VOLT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    n_writes++;
    read_reg(idx, val);
  endtask

  task automatic set_window(input logic [pss_pkg::VOLT_W-1:0] lo,
                            input logic [pss_pkg::VOLT_W-1:0] hi,
                            input logic [pss_pkg::VOLT_W-1:0] det);
    wait_idle();
    write_reg(pss_pkg::REG_MIN_VOLTAGE, lo);
    write_reg(pss_pkg::REG_MAX_VOLTAGE, hi);
    write_reg(pss_pkg::REG_DETECT_LEVEL, det);
    cfg_min = lo;
    cfg_max = hi;
    cfg_det = det;
  endtask

  task automatic test_reset_values();
    read_reg(pss_pkg::REG_MIN_VOLTAGE, pss_pkg::MIN_VOLTAGE_RST);
    read_reg(pss_pkg::REG_MAX_VOLTAGE, pss_pkg::MAX_VOLTAGE_RST);
    read_reg(pss_pkg::REG_DETECT_LEVEL, pss_pkg::DETECT_LEVEL_RST);
  endtask

  // reset window: classification and each selection rule that picks slot A or B
  task automatic test_classify();
    src_idle_pct = 31;
    snk_idle_pct = 62;
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd2000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd3000, 1'b1);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd0, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd3000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd4000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd4095, 1'b1);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd4095, 1'b1);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd100, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd99, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd50, 1'b0);
    send_check(pss_pkg::REQ_FULL, 2'd3, 12'd4095, 1'b1);
    send_check(pss_pkg::REQ_QUICK, 2'd3, 12'd0, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd100, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd50, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd10, 1'b1);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd5, 1'b1);
    n_directed += 16;
  endtask

  // strict window edges on full checks, inclusive ones on quick checks
  task automatic test_window_edges();
    set_window(12'd1000, 12'd3000, 12'd2000);
    send_check(pss_pkg::REQ_QUICK, pss_pkg::SLOT_A, 12'd999, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd1000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd1001, 1'b0);
    send_check(pss_pkg::REQ_QUICK, pss_pkg::SLOT_A, 12'd1000, 1'b1);
    send_check(pss_pkg::REQ_QUICK, pss_pkg::SLOT_A, 12'd3000, 1'b0);
    send_check(pss_pkg::REQ_QUICK, pss_pkg::SLOT_B, 12'd3001, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd3000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd2000, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd1999, 1'b0);
    n_directed += 9;
  endtask

  // min at or above max leaves no sample in the window of a full check
  task automatic test_inverted_window();
    set_window(12'd3000, 12'd1000, 12'd4095);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_A, 12'd2000, 1'b0);
    send_check(pss_pkg::REQ_QUICK, pss_pkg::SLOT_C, 12'd2000, 1'b0);
    set_window(12'd2048, 12'd2048, 12'd0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_B, 12'd2048, 1'b0);
    send_check(pss_pkg::REQ_FULL, pss_pkg::SLOT_C, 12'd0, 1'b0);
    n_directed += 4;
  endtask

  function automatic logic [pss_pkg::VOLT_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      1:       return cfg_min + 12'($urandom_range(0, 2)) - 12'd1;
      2:       return cfg_max + 12'($urandom_range(0, 2)) - 12'd1;
      3:       return cfg_det + 12'($urandom_range(0, 2)) - 12'd1;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_random_traffic(input int src_pct, input int snk_pct, input int phase);
    logic [1:0] slot;
    logic       req;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int s = 0; s < SETS_PER_PHASE; s++) begin
      if (s == 0) begin
        case (phase)
          0:       set_window(12'd0, 12'd4095, 12'd0);
          1:       set_window(12'd4095, 12'd0, 12'd4095);
          default: set_window(pss_pkg::MIN_VOLTAGE_RST, pss_pkg::MAX_VOLTAGE_RST,
                              pss_pkg::DETECT_LEVEL_RST);
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        set_window(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)));
      end else begin
        set_window(12'($urandom_range(0, 1500)), 12'($urandom_range(2500, 4095)),
                   12'($urandom_range(0, 4095)));
      end
      for (int k = 0; k < WORDS_PER_SET; k++) begin
        req  = ($urandom_range(0, 3) == 0) ? pss_pkg::REQ_QUICK : pss_pkg::REQ_FULL;
        slot = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_check(req, slot, pick_sample(), $urandom_range(0, 2) == 0);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_classify();
    test_window_edges();
    test_inverted_window();
    test_random_traffic(31, 62, 0);
    test_random_traffic(62, 31, 1);
    test_random_traffic(0, 0, 2);
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("sent %0d check words (%0d directed), compared %0d results", n_sent,
             n_directed, n_checked);
    $display("%0d register writes across window settings incl. inverted and full range",
             n_writes);
    if (n_errors == 0) begin
      $display("[power_source_selector_top] OK");
    end else begin
      $display("[power_source_selector_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pss_pkg.sv
rtl/pss_slot_bank.sv
rtl/pss_select.sv
rtl/power_source_selector_top.sv
tb/sv/tb_power_source_selector_top.sv
